// ----- src/qtts_pkg.sv -----
// ----------------------------------------------------------------------------
// qtts_pkg
// Shared constants, types and the arctangent table for the tilt-to-speed block.
// ----------------------------------------------------------------------------
package qtts_pkg;

    // fixed-point formats
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int ACC_FRAC        = 16;

    // widths
    localparam int IN_W   = 16;                    // quaternion component
    localparam int VEC_W  = 35;                    // atan2 operands, exact
    localparam int CW     = 37;                    // cordic x/y datapath
    localparam int AW     = 26;                    // cordic angle accumulator
    localparam int ANG_W  = 17;                    // rounded angle, Q9.7 plus margin
    localparam int WANG_W = 16;                    // wrapped angle, -180..180
    localparam int MAG_W  = 8 + ANGLE_FRAC_BITS;   // angle magnitude and limits
    localparam int Q_W    = QUAT_FRAC_BITS + 1;    // normalised excess 0..1
    localparam int SQ_W   = 2 * Q_W;
    localparam int SPD_W  = 16;

    // atan(2^-i) in degrees, 16 fraction bits, rounded
    localparam int ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [7:0] dead_angle;
        logic [7:0] max_speed_angle;
    } cfg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] num;
        logic signed [VEC_W-1:0] den;
    } vec_t;

endpackage

// ----- src/qtts_products.sv -----
// ----------------------------------------------------------------------------
// qtts_products
// Quaternion products and the numerator/denominator pairs for roll and pitch.
// ----------------------------------------------------------------------------
module qtts_products (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [qtts_pkg::IN_W-1:0]  quat_x,
    input  logic signed [qtts_pkg::IN_W-1:0]  quat_y,
    input  logic signed [qtts_pkg::IN_W-1:0]  quat_z,
    input  logic signed [qtts_pkg::IN_W-1:0]  quat_w,
    output logic                              out_valid,
    output qtts_pkg::vec_t                    roll_vec,
    output qtts_pkg::vec_t                    pitch_vec
);
    import qtts_pkg::*;

    localparam int PW = 2 * IN_W;
    localparam logic signed [VEC_W-1:0] ONE2 =
        VEC_W'(longint'(1) << (2 * QUAT_FRAC_BITS));

    logic                 v1_reg, v2_reg;
    logic signed [PW-1:0] xy_reg, zw_reg, yy_reg, zz_reg, xw_reg, yz_reg, ww_reg;
    vec_t                 roll_reg, pitch_reg;
    vec_t                 roll_next, pitch_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_reg <= quat_x * quat_y;
            zw_reg <= quat_z * quat_w;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            ww_reg <= quat_w * quat_w;
        end
    end

    // doubled sums
    always_comb
    begin
        roll_next.num  = (VEC_W'(xy_reg) + VEC_W'(zw_reg)) <<< 1;
        roll_next.den  = ONE2 - ((VEC_W'(yy_reg) + VEC_W'(zz_reg)) <<< 1);
        pitch_next.num = (VEC_W'(xw_reg) + VEC_W'(yz_reg)) <<< 1;
        pitch_next.den = ONE2 - ((VEC_W'(zz_reg) + VEC_W'(ww_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
        end
    end

    assign out_valid = v2_reg;
    assign roll_vec  = roll_reg;
    assign pitch_vec = pitch_reg;

endmodule

// ----- src/qtts_cordic.sv -----
// ----------------------------------------------------------------------------
// qtts_cordic
// Pipelined vectoring cordic: atan2 in degrees, rounded to Q9.7.
// ----------------------------------------------------------------------------
module qtts_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  qtts_pkg::vec_t                     vec,
    output logic                               out_valid,
    output logic signed [qtts_pkg::ANG_W-1:0]  angle
);
    import qtts_pkg::*;

    localparam int CS = CORDIC_STAGES;
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] QUARTER = AW'(90 << ACC_FRAC);
    localparam logic signed [AW-1:0] ROUND   = AW'(1 << (SH - 1));

    logic signed [CW-1:0] x_reg [0:CS];
    logic signed [CW-1:0] y_reg [0:CS];
    logic signed [AW-1:0] z_reg [0:CS];
    logic                 zero_reg [0:CS];
    logic                 vld_reg [0:CS+1];
    logic signed [ANG_W-1:0] angle_reg;

    logic signed [CW-1:0] xi, yi, xp, yp;
    logic signed [AW-1:0] zp;

    // quadrant pre-rotation into the right half plane
    always_comb
    begin
        xi = CW'(vec.den);
        yi = CW'(vec.num);
        xp = xi;
        yp = yi;
        zp = '0;
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                xp = yi;
                yp = -xi;
                zp = QUARTER;
            end
            else
            begin
                xp = -yi;
                yp = xi;
                zp = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= xp;
            y_reg[0]    <= yp;
            z_reg[0]    <= zp;
            zero_reg[0] <= (xi == 0) && (yi == 0);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CS + 1; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= CS + 1; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // micro-rotations, one per stage
    for (genvar i = 0; i < CS; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + AW'(ATAN_TAB[i]);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - AW'(ATAN_TAB[i]);
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // round half up to Q9.7, zero vector gives zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[CS])
                angle_reg <= '0;
            else
                angle_reg <= ANG_W'((z_reg[CS] + ROUND) >>> SH);
        end
    end

    assign out_valid = vld_reg[CS+1];
    assign angle     = angle_reg;

endmodule

// ----- src/qtts_speed_map.sv -----
// ----------------------------------------------------------------------------
// qtts_speed_map
// Dead-zone quadratic map of one angle, with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module qtts_speed_map (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [qtts_pkg::WANG_W-1:0]  angle,
    input  qtts_pkg::cfg_t                      cfg,
    output logic                                out_valid,
    output logic signed [qtts_pkg::SPD_W-1:0]   speed
);
    import qtts_pkg::*;

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_FULL = 2'd1;
    localparam logic [1:0] CLS_QUAD = 2'd2;

    localparam int NS = Q_W + 2;   // classify, divider stages, square
    localparam logic [SPD_W-1:0] ONE  = SPD_W'(1) << QUAT_FRAC_BITS;
    localparam logic [SQ_W:0]    HALF = (SQ_W+1)'(1) << (QUAT_FRAC_BITS - 1);

    logic [1:0]       cls_reg [0:NS-1];
    logic             neg_reg [0:NS-1];
    logic [MAG_W-1:0] rem_reg [0:Q_W];
    logic [MAG_W-1:0] den_reg [0:Q_W];
    logic [Q_W-1:0]   quo_reg [1:Q_W];
    logic             vld_reg [0:NS];
    logic [SQ_W-1:0]  sq_reg;
    logic signed [SPD_W-1:0] speed_reg;

    logic signed [WANG_W-1:0] neg_ang;
    logic [MAG_W-1:0] mag, dead, top;
    logic [1:0]       cls;
    logic [SQ_W:0]    rounded;
    logic [SPD_W-1:0] val;

    // classify against the dead zone and the saturation angle
    always_comb
    begin
        neg_ang = -angle;
        mag  = MAG_W'(angle[WANG_W-1] ? neg_ang : angle);
        dead = MAG_W'({cfg.dead_angle, {ANGLE_FRAC_BITS{1'b0}}});
        top  = MAG_W'({cfg.max_speed_angle, {ANGLE_FRAC_BITS{1'b0}}});
        if ((angle == 0) || (mag < dead))
            cls = CLS_ZERO;
        else if ((top <= dead) || (mag > top))
            cls = CLS_FULL;
        else
            cls = CLS_QUAD;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg[0] <= cls;
            neg_reg[0] <= angle[WANG_W-1];
            rem_reg[0] <= mag - dead;
            den_reg[0] <= top - dead;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // sideband through divider and square stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k < NS; k++)
            begin
                cls_reg[k] <= cls_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    // one quotient bit per stage, first stage takes the integer bit
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [MAG_W:0] trial;
        logic           ge;

        always_comb
        begin
            if (j == 0)
                trial = {1'b0, rem_reg[j]};
            else
                trial = {rem_reg[j], 1'b0};
            ge = trial >= {1'b0, den_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? MAG_W'(trial - {1'b0, den_reg[j]}) : MAG_W'(trial);
                den_reg[j+1] <= den_reg[j];
            end
        end

        if (j == 0)
        begin : g_int
            always_ff @(posedge clk)
            begin
                if (en)
                    quo_reg[j+1] <= Q_W'(ge);
            end
        end
        else
        begin : g_frac
            always_ff @(posedge clk)
            begin
                if (en)
                    quo_reg[j+1] <= {quo_reg[j][Q_W-2:0], ge};
            end
        end
    end

    // square of the normalised excess
    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= quo_reg[Q_W] * quo_reg[Q_W];
    end

    // round, select and apply sign
    always_comb
    begin
        rounded = ((SQ_W+1)'(sq_reg) + HALF) >> QUAT_FRAC_BITS;
        case (cls_reg[NS-1])
            CLS_FULL: val = ONE;
            CLS_QUAD: val = SPD_W'(rounded);
            default:  val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            speed_reg <= neg_reg[NS-1] ? -$signed(val) : $signed(val);
    end

    assign out_valid = vld_reg[NS];
    assign speed     = speed_reg;

endmodule

// ----- src/quaternion_tilt_to_speed.sv -----
// ----------------------------------------------------------------------------
// quaternion_tilt_to_speed
// Throughput: one word per cycle; the pipeline only holds while the output
// register and its skid stage are both full.
// Reset: valid bits cleared, dead_angle = 10, max_speed_angle = 30.
// Roll and pitch take a 16-stage cordic each and a 15-stage divider each.
// ----------------------------------------------------------------------------
module quaternion_tilt_to_speed (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [qtts_pkg::IN_W-1:0]   quat_x,
    input  logic signed [qtts_pkg::IN_W-1:0]   quat_y,
    input  logic signed [qtts_pkg::IN_W-1:0]   quat_z,
    input  logic signed [qtts_pkg::IN_W-1:0]   quat_w,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [qtts_pkg::SPD_W-1:0]  lateral_speed,
    output logic signed [qtts_pkg::SPD_W-1:0]  longitudinal_speed
);
    import qtts_pkg::*;

    localparam logic REG_DEAD_ANGLE = 1'b0;
    localparam logic REG_MAX_SPEED  = 1'b1;
    localparam logic [7:0] DEAD_RST = 8'd10;
    localparam logic [7:0] MAX_RST  = 8'd30;
    localparam logic signed [ANG_W:0] HALF_TURN = (ANG_W+1)'(180 << ANGLE_FRAC_BITS);

    logic [7:0] dead_angle_reg, max_speed_angle_reg;
    cfg_t       cfg;
    logic       en;

    logic       prod_valid, roll_cv, pitch_cv, roll_sv, pitch_sv, pipe_valid;
    vec_t       roll_vec, pitch_vec;
    logic signed [ANG_W-1:0]  roll_ang, pitch_ang;
    logic signed [ANG_W:0]    roll_ext, pitch_ext;
    logic signed [WANG_W-1:0] roll_w_next, pitch_w_next;
    logic signed [WANG_W-1:0] roll_w_reg, pitch_w_reg;
    logic                     wv_reg;
    logic signed [SPD_W-1:0]  roll_speed, pitch_speed;

    logic                     out_valid_reg, skid_valid_reg;
    logic signed [SPD_W-1:0]  lat_reg, long_reg, skid_lat_reg, skid_long_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_angle_reg      <= DEAD_RST;
            max_speed_angle_reg <= MAX_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_DEAD_ANGLE: dead_angle_reg      <= pwdata[7:0];
                REG_MAX_SPEED:  max_speed_angle_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_DEAD_ANGLE: prdata = {24'd0, dead_angle_reg};
            REG_MAX_SPEED:  prdata = {24'd0, max_speed_angle_reg};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg.dead_angle      = dead_angle_reg;
    assign cfg.max_speed_angle = max_speed_angle_reg;

    // pipeline advances while the skid stage is empty
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    qtts_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .out_valid (prod_valid),
        .roll_vec  (roll_vec),
        .pitch_vec (pitch_vec)
    );

    qtts_cordic u_roll_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .vec       (roll_vec),
        .out_valid (roll_cv),
        .angle     (roll_ang)
    );

    qtts_cordic u_pitch_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .vec       (pitch_vec),
        .out_valid (pitch_cv),
        .angle     (pitch_ang)
    );

    // pitch offset and wrap into -180..180
    always_comb
    begin
        roll_ext  = (ANG_W+1)'(roll_ang);
        pitch_ext = HALF_TURN - (ANG_W+1)'(pitch_ang);
        if (roll_ext > HALF_TURN)
            roll_w_next = WANG_W'(roll_ext - (HALF_TURN <<< 1));
        else if (roll_ext < -HALF_TURN)
            roll_w_next = WANG_W'(roll_ext + (HALF_TURN <<< 1));
        else
            roll_w_next = WANG_W'(roll_ext);
        if (pitch_ext > HALF_TURN)
            pitch_w_next = WANG_W'(pitch_ext - (HALF_TURN <<< 1));
        else if (pitch_ext < -HALF_TURN)
            pitch_w_next = WANG_W'(pitch_ext + (HALF_TURN <<< 1));
        else
            pitch_w_next = WANG_W'(pitch_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wv_reg <= 1'b0;
        else if (en)
            wv_reg <= roll_cv && pitch_cv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_w_reg  <= roll_w_next;
            pitch_w_reg <= pitch_w_next;
        end
    end

    qtts_speed_map u_roll_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wv_reg),
        .angle     (roll_w_reg),
        .cfg       (cfg),
        .out_valid (roll_sv),
        .speed     (roll_speed)
    );

    qtts_speed_map u_pitch_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wv_reg),
        .angle     (pitch_w_reg),
        .cfg       (cfg),
        .out_valid (pitch_sv),
        .speed     (pitch_speed)
    );

    assign pipe_valid = roll_sv && pitch_sv;

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= pipe_valid;
        end
        else if (pipe_valid && en)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                lat_reg  <= skid_lat_reg;
                long_reg <= skid_long_reg;
            end
            else
            begin
                lat_reg  <= -roll_speed;
                long_reg <= pitch_speed;
            end
        end
        else if (en)
        begin
            skid_lat_reg  <= -roll_speed;
            skid_long_reg <= pitch_speed;
        end
    end

    assign out_valid          = out_valid_reg;
    assign lateral_speed      = lat_reg;
    assign longitudinal_speed = long_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (lat_reg <= 16'sd16384 && lat_reg >= -16'sd16384))
        else $error("lateral speed out of range");

    a_long_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (long_reg <= 16'sd16384 && long_reg >= -16'sd16384))
        else $error("longitudinal speed out of range");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        roll_sv == pitch_sv)
        else $error("roll and pitch lanes out of step");

endmodule

// ----- tb/quaternion_tilt_to_speed_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_tilt_to_speed_test
// Self-checking bench for the tilt-to-speed block: quaternion words are sent
// under random flow control, each output word is compared with a fixed-point
// prediction of roll and pitch speed, over several dead and max angle settings.
// ----------------------------------------------------------------------------
module quaternion_tilt_to_speed_test;
    import qtts_pkg::*;

    localparam logic [2:0] ADDR_DEAD = 3'd0;
    localparam logic [2:0] ADDR_MAX  = 3'd4;
    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] lat;
        logic signed [15:0] lon;
    } speed_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] lateral_speed, longitudinal_speed;

    // predictor copy of the registers
    logic [7:0] dead_deg = 8'd10;
    logic [7:0] max_deg = 8'd30;

    speed_pair_t expected_speeds[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_out = 1'b0;
    int hold_len = 0;

    quaternion_tilt_to_speed dut (.*);

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // atan2 in degrees with 16 fraction bits
    function automatic longint atan2_deg(longint yv, longint xv);
        longint ang, t, nx, ny;
        ang = 0;
        if (yv == 0 && xv == 0)
            return 0;
        while ((yv < 0 ? -yv : yv) >= (64'sd1 <<< 40) || (xv < 0 ? -xv : xv) >= (64'sd1 <<< 40))
        begin
            yv = floor_shr(yv, 1);
            xv = floor_shr(xv, 1);
        end
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t = xv; xv = yv; yv = -t; ang = 90 <<< ACC_FRAC;
            end
            else
            begin
                t = xv; xv = -yv; yv = t; ang = -(90 <<< ACC_FRAC);
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (yv > 0)
            begin
                nx = xv + floor_shr(yv, i); ny = yv - floor_shr(xv, i);
                ang += atan_entry(i);
            end
            else
            begin
                nx = xv - floor_shr(yv, i); ny = yv + floor_shr(xv, i);
                ang -= atan_entry(i);
            end
            xv = nx; yv = ny;
        end
        return ang;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return tab[i];
    endfunction

    function automatic longint round_wrap(longint acc, bit flip);
        longint a, half;
        half = 180 <<< ANGLE_FRAC_BITS;
        a = floor_shr(acc + (1 <<< (ACC_FRAC - ANGLE_FRAC_BITS - 1)), ACC_FRAC - ANGLE_FRAC_BITS);
        if (flip)
            a = half - a;
        if (a > half)
            a -= 2 * half;
        else if (a < -half)
            a += 2 * half;
        return a;
    endfunction

    // dead-zone quadratic map
    function automatic longint tilt_speed(longint a);
        longint dz, top, mag, sgn, q, sq;
        dz = longint'(dead_deg) <<< ANGLE_FRAC_BITS;
        top = longint'(max_deg) <<< ANGLE_FRAC_BITS;
        mag = a < 0 ? -a : a;
        sgn = a < 0 ? -1 : 1;
        if (a == 0 || mag < dz)
            return 0;
        if (top <= dz || mag > top)
            return sgn * (1 <<< QUAT_FRAC_BITS);
        q = ((mag - dz) <<< QUAT_FRAC_BITS) / (top - dz);
        sq = (q * q + (1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
        return sgn * sq;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic speed_pair_t predict_speeds(longint x, longint y, longint z, longint w);
        speed_pair_t r;
        longint one2, roll, pitch;
        one2 = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
        roll = round_wrap(atan2_deg(2 * (x * y + z * w), one2 - 2 * (y * y + z * z)), 1'b0);
        pitch = round_wrap(atan2_deg(2 * (x * w + y * z), one2 - 2 * (z * z + w * w)), 1'b1);
        r.lat = sat16(-tilt_speed(roll));
        r.lon = sat16(tilt_speed(pitch));
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 40)
            return 0;
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // apb register write
    task automatic write_reg(logic [2:0] addr, logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_DEAD)
            dead_deg = value;
        else
            max_deg = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // stop offering, wait for every result, end on a falling edge
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_angles(logic [7:0] dz, logic [7:0] top);
        wait_drained();
        write_reg(ADDR_DEAD, dz);
        write_reg(ADDR_MAX, top);
    endtask

    // send one word, called on a falling edge, returns on a falling edge
    task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic signed [15:0] w, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
        do @(posedge clk); while (!in_ready);
        expected_speeds.push_back(predict_speeds(x, y, z, w));
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b1);
            else
                send_quat(16'($urandom_range(0, 4000) - 2000),
                          16'($urandom_range(0, 4000) - 2000),
                          16'($urandom_range(0, 32768) - 16384),
                          16'($urandom_range(0, 32768) - 16384),
                          1'b1);
        end
    endtask

    // directed corners: zero vector, identity-like, extremes, bit patterns
    task automatic test_directed();
        send_quat(0, 0, 0, 0, 1'b0);
        send_quat(0, 0, 0, 16384, 1'b0);
        send_quat(0, 0, 16384, 0, 1'b0);
        send_quat(16384, 0, 0, 0, 1'b0);
        send_quat(0, 16384, 0, 0, 1'b0);
        send_quat(-16384, -16384, -16384, -16384, 1'b0);
        send_quat(16384, 16384, 16384, 16384, 1'b0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
        send_quat(16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh1234, 1'b0);
        send_quat(1000, 0, 2000, 16000, 1'b0);
        send_quat(0, 3000, -2000, 15000, 1'b0);
        send_quat(11585, 11585, 0, 0, 1'b0);
        send_quat(0, 0, 11585, 11585, 1'b0);
    endtask

    task automatic test_settings();
        set_angles(8'd0, 8'd180);   send_random(150);
        set_angles(8'd180, 8'd0);   send_random(100);
        set_angles(8'd20, 8'd20);   send_random(100);
        set_angles(8'd255, 8'd255); send_random(50);
        set_angles(8'd0, 8'd0);     send_random(100);
        set_angles(8'd5, 8'd90);    send_random(200);
        set_angles(8'd10, 8'd30);   send_random(200);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_len = 300;
        hold_out = 1'b1;
        send_random(150);
        wait_drained();
        wait (!hold_out);
        send_random(200);
    endtask

    // receiver side
    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_out = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                g = ($urandom_range(0, 99) < 30) ? gap_len() : 0;
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // result check
    always @(posedge clk)
    begin
        speed_pair_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word lat=%0d lon=%0d", lateral_speed, longitudinal_speed);
            end
            else
            begin
                e = expected_speeds.pop_front();
                if (e.lat !== lateral_speed || e.lon !== longitudinal_speed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp lat=%0d lon=%0d got lat=%0d lon=%0d",
                                 e.lat, e.lon, lateral_speed, longitudinal_speed);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        send_random(150);
        test_settings();
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && expected_speeds.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/qtts_pkg.sv
src/qtts_products.sv
src/qtts_cordic.sv
src/qtts_speed_map.sv
src/quaternion_tilt_to_speed.sv
tb/quaternion_tilt_to_speed_test.sv
